[rtl/utf8_to_utf16_transcoder_unit_macros.svh]
// assertion macros for the utf-8 to utf-16 transcoder
// used by the top level only, expects clk and rst_n in scope
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

// same-cycle implication
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/u8u16_pkg.sv]
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies
package u8u16_pkg;

    localparam int MAX_UNITS = 4;

    localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
    localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
    localparam logic [20:0] CP_MIN_2BYTE  = 21'h000080;
    localparam logic [20:0] CP_MIN_3BYTE  = 21'h000800;
    localparam logic [20:0] CP_MIN_4BYTE  = 21'h010000;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;

    typedef struct packed {
        logic [15:0] code;
        logic        replaced;
    } unit_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_last;
        logic        text_last;
    } entry_t;

    typedef struct packed {
        unit_t [MAX_UNITS-1:0] units;
        logic [2:0]            unit_count;
        logic [2:0][7:0]       pend_bytes;
        logic [1:0]            pend_count;
    } dec_result_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

endpackage

[rtl/u8u16_decode.sv]
// window decoder: pending bytes plus one new byte to up to four utf-16 units
// depends on u8u16_pkg
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic [2:0][7:0] pend_bytes,
    input  logic [1:0]      pend_count,
    input  logic [7:0]      in_byte,
    input  logic            end_of_text,
    output dec_result_t     res
);

    logic [7:0]  win [4];
    logic [2:0]  n;
    logic [2:0]  pos;
    logic [2:0]  k;
    logic [2:0]  avail;
    logic [2:0]  need;
    logic [2:0]  rem;
    logic [1:0]  p1;
    logic [1:0]  p2;
    logic [1:0]  p3;
    logic [7:0]  b;
    logic [20:0] cp;
    logic [19:0] v;
    logic        stop;
    logic        bad;

    always_comb
    begin
        win[0] = (pend_count == 2'd0) ? in_byte : pend_bytes[0];
        win[1] = (pend_count == 2'd1) ? in_byte :
                 (pend_count > 2'd1)  ? pend_bytes[1] : 8'd0;
        win[2] = (pend_count == 2'd2) ? in_byte :
                 (pend_count == 2'd3) ? pend_bytes[2] : 8'd0;
        win[3] = (pend_count == 2'd3) ? in_byte : 8'd0;
    end

    always_comb
    begin
        res   = '0;
        n     = {1'b0, pend_count} + 3'd1;
        pos   = 3'd0;
        k     = 3'd0;
        stop  = 1'b0;
        b     = 8'd0;
        avail = 3'd0;
        need  = 3'd0;
        bad   = 1'b0;
        cp    = 21'd0;
        v     = 20'd0;
        p1    = 2'd0;
        p2    = 2'd0;
        p3    = 2'd0;
        for (int it = 0; it < MAX_UNITS; it++)
        begin
            if (!stop && pos < n)
            begin
                b     = win[pos[1:0]];
                avail = n - pos;
                p1    = pos[1:0] + 2'd1;
                p2    = pos[1:0] + 2'd2;
                p3    = pos[1:0] + 2'd3;
                bad   = 1'b0;
                need  = 3'd0;
                cp    = 21'd0;
                if (b < ASCII_LIMIT)
                begin
                    if (k < 3'd4)
                    begin
                        res.units[k[1:0]] = '{code: {8'd0, b}, replaced: 1'b0};
                        k = k + 3'd1;
                    end
                    pos = pos + 3'd1;
                end
                else
                begin
                    if (b[7:5] == 3'b110)
                        need = 3'd2;
                    else if (b[7:4] == 4'b1110)
                        need = 3'd3;
                    else if (b[7:3] == 5'b11110)
                        need = 3'd4;
                    if (need == 3'd0)
                    begin
                        if (k < 3'd4)
                        begin
                            res.units[k[1:0]] = '{code: REPL_UNIT, replaced: 1'b1};
                            k = k + 3'd1;
                        end
                        pos = pos + 3'd1;
                    end
                    else
                    begin
                        bad = (avail > 3'd1 && !is_cont(win[p1])) ||
                              (need > 3'd2 && avail > 3'd2 && !is_cont(win[p2])) ||
                              (need == 3'd4 && avail > 3'd3 && !is_cont(win[p3]));
                        if (!bad && avail < need)
                        begin
                            if (!end_of_text)
                                stop = 1'b1;
                            else
                                bad = 1'b1;
                        end
                        if (!stop)
                        begin
                            if (!bad)
                            begin
                                case (need)
                                    3'd2:
                                    begin
                                        cp  = {10'd0, b[4:0], win[p1][5:0]};
                                        bad = cp < CP_MIN_2BYTE;
                                    end
                                    3'd3:
                                    begin
                                        cp  = {5'd0, b[3:0], win[p1][5:0], win[p2][5:0]};
                                        bad = cp < CP_MIN_3BYTE ||
                                              (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
                                    end
                                    default:
                                    begin
                                        cp  = {b[2:0], win[p1][5:0], win[p2][5:0],
                                               win[p3][5:0]};
                                        bad = cp < CP_MIN_4BYTE || cp > CP_MAX;
                                    end
                                endcase
                            end
                            if (bad)
                            begin
                                if (k < 3'd4)
                                begin
                                    res.units[k[1:0]] = '{code: REPL_UNIT, replaced: 1'b1};
                                    k = k + 3'd1;
                                end
                                pos = pos + 3'd1;
                            end
                            else if (need == 3'd4)
                            begin
                                v = 20'(cp - CP_MIN_4BYTE);
                                if (k < 3'd4)
                                begin
                                    res.units[k[1:0]] = '{code: HIGH_SURR + {6'd0, v[19:10]},
                                                          replaced: 1'b0};
                                    k = k + 3'd1;
                                end
                                if (k < 3'd4)
                                begin
                                    res.units[k[1:0]] = '{code: LOW_SURR + {6'd0, v[9:0]},
                                                          replaced: 1'b0};
                                    k = k + 3'd1;
                                end
                                pos = pos + need;
                            end
                            else
                            begin
                                if (k < 3'd4)
                                begin
                                    res.units[k[1:0]] = '{code: cp[15:0], replaced: 1'b0};
                                    k = k + 3'd1;
                                end
                                pos = pos + need;
                            end
                        end
                    end
                end
            end
        end
        rem = n - pos;
        for (int j = 0; j < 3; j++)
        begin
            if (3'(j) < rem)
                res.pend_bytes[j] = win[2'(pos[1:0] + 2'(j))];
        end
        res.pend_count = rem[1:0];
        res.unit_count = k;
    end

endmodule

[rtl/u8u16_unit_fifo.sv]
// output queue of utf-16 units, takes up to four per cycle, gives one
// depends on u8u16_pkg
module u8u16_unit_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [2:0]              push_count,
    input  entry_t [MAX_UNITS-1:0]  push_data,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output entry_t                  out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   wr_idx [MAX_UNITS];
    logic            pop;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] ptr,
                                               input logic [2:0] inc);
        logic [AW+2:0] s;
        s = {3'd0, ptr} + (AW+3)'(inc);
        if (s >= (AW+3)'(DEPTH))
            s = s - (AW+3)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign room      = count_reg <= CW'(DEPTH - MAX_UNITS);

    always_comb
    begin
        for (int j = 0; j < MAX_UNITS; j++)
            wr_idx[j] = wrap_add(wr_ptr_reg, 3'(j));
        wr_ptr_next = push ? wrap_add(wr_ptr_reg, push_count) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_add(rd_ptr_reg, 3'd1) : rd_ptr_reg;
        count_next  = count_reg + (push ? CW'(push_count) : CW'(0)) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_UNITS; j++)
        begin
            if (push && 3'(j) < push_count)
                mem[wr_idx[j]] <= push_data[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/utf8_to_utf16_transcoder_unit.sv]
// utf-8 to utf-16 transcoder, top level: input register, decoder, output queue
// a byte waits in the input register until the queue has room, then its units are written into the output queue
// throughput: one byte per cycle while each byte gives at most one unit; units leave
// the output queue one per cycle, and input stalls while the queue holds more than
// FIFO_DEPTH-4 units
// reset: asynchronous, clears input valid, pending count and queue pointers
module utf8_to_utf16_transcoder_unit
    import u8u16_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_unit
    output logic [1:0]  m_tuser,   // replaced, run_last
    output logic        m_tlast    // text_last
);

`include "utf8_to_utf16_transcoder_unit_macros.svh"

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_eot_reg;
    logic [2:0][7:0]        pend_bytes_reg;
    logic [1:0]             pend_count_reg;
    logic [1:0]             pend_count_next;
    logic                   load;
    logic                   consume;
    logic                   fifo_room;
    logic                   push;
    dec_result_t            dec;
    entry_t [MAX_UNITS-1:0] entries;
    entry_t                 head;

    assign consume  = in_valid_reg && fifo_room;
    assign s_tready = !in_valid_reg || fifo_room;
    assign load     = s_tvalid && s_tready;
    assign push     = consume && (dec.unit_count != 3'd0);

    u8u16_decode u_decode (
        .pend_bytes  (pend_bytes_reg),
        .pend_count  (pend_count_reg),
        .in_byte     (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res         (dec)
    );

    always_comb
    begin
        for (int j = 0; j < MAX_UNITS; j++)
        begin
            entries[j].code_unit = dec.units[j].code;
            entries[j].replaced  = dec.units[j].replaced;
            entries[j].run_last  = 3'(j) == dec.unit_count - 3'd1;
            entries[j].text_last = (3'(j) == dec.unit_count - 3'd1) && in_eot_reg;
        end
        in_valid_next   = load ? 1'b1 : (consume ? 1'b0 : in_valid_reg);
        pend_count_next = consume ? dec.pend_count : pend_count_reg;
    end

    u8u16_unit_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_count (dec.unit_count),
        .push_data  (entries),
        .room       (fifo_room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (head)
    );

    assign m_tdata = head.code_unit;
    assign m_tuser = {head.run_last, head.replaced};
    assign m_tlast = head.text_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (consume)
            pend_bytes_reg <= dec.pend_bytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pend_count_reg <= 2'd0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            pend_count_reg <= pend_count_next;
        end
    end

    // end of text flushes the pending window
    `U8U16_ASSERT_NEXT(a_eot_flush, consume && in_eot_reg, pend_count_reg == 2'd0, "pending bytes left after end of text")
    // end of text always yields at least one unit
    `U8U16_ASSERT_NOW(a_eot_units, consume && in_eot_reg, dec.unit_count != 3'd0, "no unit for end of text byte")
    // a pending window always starts with a multi-byte lead
    `U8U16_ASSERT_NOW(a_pend_lead, pend_count_reg != 2'd0, pend_bytes_reg[0][7:6] == 2'b11 && pend_bytes_reg[0] < 8'hF8, "pending window without a lead byte")

endmodule

[test/utf8_to_utf16_transcoder_unit_checker.sv]
`timescale 1ns / 100ps
// checker for the utf-8 to utf-16 transcoder: watches both stream channels, predicts
// the code units of every accepted byte and compares each output transaction in order
// depends on u8u16_pkg for the code unit entry type
module utf8_to_utf16_transcoder_unit_checker
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_of_text
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // code_unit
    input  logic [1:0]  m_tuser,   // replaced, run_last
    input  logic        m_tlast,   // text_last
    output int          fail_count,
    output int          waiting
);

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    entry_t     expected_units [$];
    logic [7:0] held_bytes [0:2];
    int         held_count = 0;
    int         mismatches = 0;

    // decode one byte against the held bytes and queue the code units it yields
    task automatic decode_byte(input logic [7:0] in_byte, input logic eot);
        logic [7:0]  win [0:3];
        entry_t      units [0:3];
        logic [7:0]  lead;
        logic [20:0] cp;
        logic [20:0] offs;
        logic        bad;
        logic        stop;
        int          n;
        int          pos;
        int          need;
        int          avail;
        int          have;
        int          k;
        int          i;
        n = held_count;
        for (i = 0; i < n; i++)
            win[i] = held_bytes[i];
        win[n] = in_byte;
        n++;
        pos = 0;
        k = 0;
        stop = 1'b0;
        while (pos < n && !stop)
        begin
            lead = win[pos];
            avail = n - pos;
            bad = 1'b0;
            cp = '0;
            if (lead < 8'h80)
                need = 1;
            else if ((lead & 8'hE0) == 8'hC0)
                need = 2;
            else if ((lead & 8'hF0) == 8'hE0)
                need = 3;
            else if ((lead & 8'hF8) == 8'hF0)
                need = 4;
            else
                need = 0;
            if (need == 0)
                bad = 1'b1;
            else if (need == 1)
                cp = {13'd0, lead};
            else
            begin
                have = (avail < need) ? avail : need;
                for (i = 1; i < have; i++)
                    if ((win[pos + i] & 8'hC0) != 8'h80)
                        bad = 1'b1;
                if (!bad && avail < need)
                begin
                    if (eot)
                        bad = 1'b1;
                    else
                        stop = 1'b1;
                end
                if (!bad && !stop)
                begin
                    if (need == 2)
                    begin
                        cp = {10'd0, lead[4:0], win[pos + 1][5:0]};
                        bad = cp < 21'h80;
                    end
                    else if (need == 3)
                    begin
                        cp = {5'd0, lead[3:0], win[pos + 1][5:0], win[pos + 2][5:0]};
                        bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
                    end
                    else
                    begin
                        cp = {lead[2:0], win[pos + 1][5:0], win[pos + 2][5:0],
                              win[pos + 3][5:0]};
                        bad = cp < 21'h10000 || cp > 21'h10FFFF;
                    end
                end
            end
            if (stop)
                ;
            else if (bad)
            begin
                if (k < 4)
                begin
                    units[k] = '{REPLACEMENT, 1'b1, 1'b0, 1'b0};
                    k++;
                end
                pos++;
            end
            else if (need == 4)
            begin
                offs = cp - 21'h10000;
                if (k < 4)
                begin
                    units[k] = '{16'hD800 + {6'd0, offs[19:10]}, 1'b0, 1'b0, 1'b0};
                    k++;
                end
                if (k < 4)
                begin
                    units[k] = '{16'hDC00 + {6'd0, offs[9:0]}, 1'b0, 1'b0, 1'b0};
                    k++;
                end
                pos += 4;
            end
            else
            begin
                if (k < 4)
                begin
                    units[k] = '{cp[15:0], 1'b0, 1'b0, 1'b0};
                    k++;
                end
                pos += need;
            end
        end
        for (i = 0; pos + i < n && i < 3; i++)
            held_bytes[i] = win[pos + i];
        held_count = i;
        if (k > 0)
        begin
            units[k - 1].run_last = 1'b1;
            units[k - 1].text_last = eot;
        end
        for (i = 0; i < k; i++)
            expected_units.push_back(units[i]);
    endtask

    always @(posedge clk)
    begin
        entry_t got;
        entry_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.code_unit = m_tdata;
                got.replaced = m_tuser[0];
                got.run_last = m_tuser[1];
                got.text_last = m_tlast;
                if (expected_units.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected unit %h repl %b run_last %b text_last %b",
                                 $time, got.code_unit, got.replaced, got.run_last,
                                 got.text_last);
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (got.code_unit !== want.code_unit || got.replaced !== want.replaced ||
                        got.run_last !== want.run_last || got.text_last !== want.text_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected unit %h repl %b run_last %b text_last %b, got %h %b %b %b",
                                     $time, want.code_unit, want.replaced, want.run_last,
                                     want.text_last, got.code_unit, got.replaced,
                                     got.run_last, got.text_last);
                    end
                end
            end
        end
        fail_count <= mismatches;
        waiting <= expected_units.size();
    end

endmodule

[test/tb_utf8_to_utf16_transcoder_unit.sv]
`timescale 1ns / 100ps
// testbench top for the utf-8 to utf-16 transcoder: drives directed and random byte
// streams with random idling on both sides and gives the verdict
// depends on utf8_to_utf16_transcoder_unit and utf8_to_utf16_transcoder_unit_checker
module tb_utf8_to_utf16_transcoder_unit;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;
    int          fail_count;
    int          waiting;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          byte_count = 0;
    logic [7:0]  seq_bytes [0:3];
    int          seq_len = 0;
    logic [8:0]  directed [$];

    always #5 clk = ~clk;

    utf8_to_utf16_transcoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_to_utf16_transcoder_unit_checker unit_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_trigger != hold_ack)
        begin
            hold_ack <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        byte_count++;
    endtask

    // utf-8 form of cp in len bytes, overlong and out of range values allowed
    task automatic encode(input logic [20:0] cp, input int len);
        case (len)
            1: seq_bytes[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq_bytes[0] = {3'b110, cp[10:6]};
                seq_bytes[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq_bytes[0] = {4'b1110, cp[15:12]};
                seq_bytes[1] = {2'b10, cp[11:6]};
                seq_bytes[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq_bytes[0] = {5'b11110, cp[20:18]};
                seq_bytes[1] = {2'b10, cp[17:12]};
                seq_bytes[2] = {2'b10, cp[11:6]};
                seq_bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
        seq_len = len;
    endtask

    task automatic send_random_char();
        logic [20:0] cp;
        logic [7:0]  b;
        logic        last;
        int          pick;
        int          len;
        int          cut;
        int          i;
        pick = $urandom_range(99);
        last = ($urandom_range(9) == 0);
        if (pick < 25)
            encode(21'($urandom_range(0, 'h7F)), 1);
        else if (pick < 40)
            encode(21'($urandom_range('h80, 'h7FF)), 2);
        else if (pick < 55)
        begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 21'hD800 && cp <= 21'hDFFF)
                cp = cp ^ 21'h2000;
            encode(cp, 3);
        end
        else if (pick < 68)
            encode(21'($urandom_range('h10000, 'h10FFFF)), 4);
        else if (pick < 80)
        begin
            // raw noise bytes
            seq_len = $urandom_range(1, 3);
            for (i = 0; i < seq_len; i++)
                seq_bytes[i] = 8'($urandom_range(255));
        end
        else if (pick < 86)
        begin
            // overlong forms
            len = $urandom_range(2, 4);
            case (len)
                2: cp = 21'($urandom_range(0, 'h7F));
                3: cp = 21'($urandom_range(0, 'h7FF));
                default: cp = 21'($urandom_range(0, 'hFFFF));
            endcase
            encode(cp, len);
        end
        else if (pick < 90)
        begin
            if ($urandom_range(1))
                encode(21'($urandom_range('hD800, 'hDFFF)), 3);
            else
                encode(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end
        else
        begin
            // broken sequence: truncated or with a bad continuation byte
            len = $urandom_range(2, 4);
            case (len)
                2: cp = 21'($urandom_range('h80, 'h7FF));
                3: cp = 21'($urandom_range('h800, 'hD7FF));
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            encode(cp, len);
            if ($urandom_range(1))
            begin
                seq_len = $urandom_range(1, len - 1);
                last = ($urandom_range(2) == 0);
            end
            else
            begin
                cut = $urandom_range(1, len - 1);
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                seq_bytes[cut] = b;
            end
        end
        for (i = 0; i < seq_len; i++)
            send_byte(seq_bytes[i], last && (i == seq_len - 1));
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int count);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = byte_count + count;
        while (byte_count < target)
            send_random_char();
    endtask

    initial
    begin
        // ascii extremes, 2/3 byte minimums, 4 byte maximum, bad leads, overlong,
        // surrogate, above range, missing continuation, cut short at end of text
        directed = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0E0, 9'h0A0, 9'h080,
                     9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0C0,
                     9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080,
                     9'h080, 9'h0E2, 9'h041, 9'h0F0, 9'h19F};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][8]);
        run_phase(31, 49, 90);
        run_phase(49, 31, 90);
        run_phase(0, 0, 40);
        // long receiver hold-off while bytes keep coming
        hold_trigger <= ~hold_trigger;
        run_phase(0, 0, 40);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
